@@ rtl/mpct_pkg.sv @@
package mpct_pkg;

  localparam int POS_W    = 12;
  localparam int SCREEN_W = 13;
  localparam int DELTA_W  = 10;
  localparam int CSIZE_W  = 7;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [SCREEN_W-1:0]        screen_t;
  typedef logic signed [DELTA_W-1:0]  delta_t;
  typedef logic [CSIZE_W-1:0]         csize_t;
  typedef logic [1:0]                 button_t;

  localparam csize_t CURSOR_WIDTH  = 7'd10;
  localparam csize_t CURSOR_HEIGHT = 7'd17;

  localparam screen_t SCREEN_WIDTH_RESET  = 13'd1024;
  localparam screen_t SCREEN_HEIGHT_RESET = 13'd768;
  localparam pos_t    POS_X_RESET         = 12'd512;
  localparam pos_t    POS_Y_RESET         = 12'd384;

  localparam button_t BTN_NONE   = 2'd0;
  localparam button_t BTN_LEFT   = 2'd1;
  localparam button_t BTN_RIGHT  = 2'd2;
  localparam button_t BTN_MIDDLE = 2'd3;

  localparam logic [2:0] STATUS_LEFT   = 3'b001;
  localparam logic [2:0] STATUS_RIGHT  = 3'b010;
  localparam logic [2:0] STATUS_MIDDLE = 3'b100;

  localparam int STATUS_X_SIGN = 4;
  localparam int STATUS_Y_SIGN = 5;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Only a single pressed button counts; chords decode to none.
  function automatic button_t decode_button(input logic [2:0] bits);
    button_t code;
    unique case (bits)
      STATUS_LEFT:   code = BTN_LEFT;
      STATUS_RIGHT:  code = BTN_RIGHT;
      STATUS_MIDDLE: code = BTN_MIDDLE;
      default:       code = BTN_NONE;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/mpct_if.sv @@
interface mpct_packet_if;
  import mpct_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [7:0] x_move_byte;
  logic [7:0] y_move_byte;

  modport source (output valid, status_byte, x_move_byte, y_move_byte, input ready);
  modport sink   (input valid, status_byte, x_move_byte, y_move_byte, output ready);
endinterface

interface mpct_cursor_if;
  import mpct_pkg::*;

  logic    valid;
  logic    ready;
  pos_t    cursor_x;
  pos_t    cursor_y;
  button_t button_code;
  logic    click_valid;
  button_t click_button;

  modport source (output valid, cursor_x, cursor_y, button_code, click_valid, click_button,
                  input ready);
  modport sink   (input valid, cursor_x, cursor_y, button_code, click_valid, click_button,
                  output ready);
endinterface

@@ rtl/mpct_axis_clamp.sv @@
module mpct_axis_clamp (
  input  mpct_pkg::pos_t    pos,
  input  mpct_pkg::delta_t  delta,
  input  mpct_pkg::screen_t screen,
  input  mpct_pkg::csize_t  cursor_size,
  output mpct_pkg::pos_t    pos_next
);
  import mpct_pkg::*;

  localparam int SUM_W = SCREEN_W + 1;
  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((1 << POS_W) - 1);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] limit;
  logic signed [SUM_W-1:0] limit_sat;
  logic signed [SUM_W-1:0] bounded;

  assign sum   = $signed({{(SUM_W-POS_W){1'b0}}, pos})
               + $signed({{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta});
  assign limit = $signed({1'b0, screen})
               - $signed({{(SUM_W-CSIZE_W){1'b0}}, cursor_size});

  // A negative bound falls through to the lower clamp and gives zero.
  always_comb begin
    limit_sat = (limit > POS_MAX) ? POS_MAX : limit;
    bounded   = (sum >= limit_sat) ? limit_sat : sum;
    if (bounded < 0) begin
      bounded = '0;
    end
  end

  assign pos_next = bounded[POS_W-1:0];

endmodule

@@ rtl/mouse_packet_cursor_tracker_unit.sv @@
// Channel  | Role   | Payload
// ---------+--------+------------------------------------------------------------
// packet   | sink   | status_byte, x_move_byte, y_move_byte
// cursor   | source | cursor_x, cursor_y, button_code, click_valid, click_button
// APB      | slave  | 0x0 screen_width, 0x4 screen_height (13 bits each)
//
// Each packet gives one beat on cursor, passing through the input register and
// then the output register. A packet can be taken every cycle while the output
// is not stalled; the cursor update and clamp run combinationally between them.
// A stalled output holds the beat and the input register fills behind it.
// Synchronous reset puts the cursor at 512,384, clears the latched button and
// loads the default 1024x768 screen.
module mouse_packet_cursor_tracker_unit (
  input  logic                         clk,
  input  logic                         rst,
  mpct_packet_if.sink                  packet,
  mpct_cursor_if.source                cursor,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mpct_pkg::ADDR_W-1:0]  paddr,
  input  logic [mpct_pkg::DATA_W-1:0]  pwdata,
  output logic [mpct_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import mpct_pkg::*;

  screen_t screen_width;
  screen_t screen_height;

  logic       in_valid;
  logic [7:0] in_status;
  logic [7:0] in_x;
  logic [7:0] in_y;

  pos_t    pos_x;
  pos_t    pos_y;
  button_t held_button;

  logic    out_valid;
  pos_t    out_x;
  pos_t    out_y;
  button_t out_button;
  logic    out_click;
  button_t out_click_button;

  logic    advance;
  logic    cfg_write;
  logic    reg_sel;
  button_t button;
  delta_t  dx;
  delta_t  dy;
  pos_t    pos_x_next;
  pos_t    pos_y_next;
  logic    click;

  // Configuration registers
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SCREEN_WIDTH:  prdata = {{(DATA_W-SCREEN_W){1'b0}}, screen_width};
      REG_SCREEN_HEIGHT: prdata = {{(DATA_W-SCREEN_W){1'b0}}, screen_height};
      default:           prdata = '0;
    endcase
  end

  // Handshake: the input register moves on whenever the output register is free.
  assign advance      = in_valid && (!out_valid || cursor.ready);
  assign packet.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (packet.valid && packet.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (packet.valid && packet.ready) begin
      in_status <= packet.status_byte;
      in_x      <= packet.x_move_byte;
      in_y      <= packet.y_move_byte;
    end
  end

  // Decode: X is a 9-bit two's complement value; Y is negated so rows grow downward.
  assign button = decode_button(in_status[2:0]);
  assign dx     = $signed({{(DELTA_W-9){in_status[STATUS_X_SIGN]}},
                           in_status[STATUS_X_SIGN], in_x});
  assign dy     = $signed({1'b0, in_status[STATUS_Y_SIGN], 8'h00})
                - $signed({{(DELTA_W-8){1'b0}}, in_y});
  assign click  = (button == BTN_NONE) && (held_button != BTN_NONE);

  mpct_axis_clamp u_clamp_x (
    .pos         (pos_x),
    .delta       (dx),
    .screen      (screen_width),
    .cursor_size (CURSOR_WIDTH),
    .pos_next    (pos_x_next)
  );

  mpct_axis_clamp u_clamp_y (
    .pos         (pos_y),
    .delta       (dy),
    .screen      (screen_height),
    .cursor_size (CURSOR_HEIGHT),
    .pos_next    (pos_y_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= POS_X_RESET;
      pos_y       <= POS_Y_RESET;
      held_button <= BTN_NONE;
    end else if (advance) begin
      pos_x       <= pos_x_next;
      pos_y       <= pos_y_next;
      held_button <= button;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (cursor.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x            <= pos_x_next;
      out_y            <= pos_y_next;
      out_button       <= button;
      out_click        <= click;
      out_click_button <= click ? held_button : BTN_NONE;
    end
  end

  assign cursor.valid        = out_valid;
  assign cursor.cursor_x     = out_x;
  assign cursor.cursor_y     = out_y;
  assign cursor.button_code  = out_button;
  assign cursor.click_valid  = out_click;
  assign cursor.click_button = out_click_button;

`ifndef NO_ASSERTIONS
  // The beat on the output always shows the position the tracker keeps.
  a_pos_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_x == pos_x) && (out_y == pos_y))
    else $error("output position differs from kept position");

  // A click names a real button and only ends on a packet with no button.
  a_click_button: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_click |-> (out_click_button != BTN_NONE) && (out_button == BTN_NONE))
    else $error("click beat with bad button fields");

  a_no_click_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_click |-> out_click_button == BTN_NONE)
    else $error("click_button set without a click");

  // The latch follows the button of the last delivered packet.
  a_latch_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> held_button == out_button)
    else $error("latched button out of step with output");

  // A packet moves into the output register only when that register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cursor.ready |=> out_valid && $stable(out_x) && $stable(out_click))
    else $error("stalled output beat was overwritten");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import mpct_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 290;
  localparam int PHASE_COUNT  = 6;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] xmove;
    logic [7:0] ymove;
  } packet_t;

  typedef struct packed {
    pos_t    x;
    pos_t    y;
    button_t btn;
    logic    click;
    button_t click_btn;
  } cursor_beat_t;

  typedef struct packed {
    packet_t      pkt;
    logic         fixed;
    cursor_beat_t beat;
  } directed_row_t;

  localparam cursor_beat_t NO_BEAT = '0;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  mpct_packet_if packet_bus ();
  mpct_cursor_if cursor_bus ();

  mouse_packet_cursor_tracker_unit dut (
    .clk     (clk),
    .rst     (rst),
    .packet  (packet_bus),
    .cursor  (cursor_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Tracker state as the block should hold it.
  pos_t    trk_x;
  pos_t    trk_y;
  button_t held_btn;
  int      screen_w_cfg;
  int      screen_h_cfg;

  cursor_beat_t  pending_cursor_beats[$];
  directed_row_t directed_rows[$];

  int src_idle_pct;
  int snk_idle_pct;
  int stall_request;
  int cycle_count;
  int packets_sent;
  int beats_checked;
  int clicks_seen;
  int cursor_mismatches;
  int settings_used;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected", cycle_count,
               pending_cursor_beats.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic pos_t clamp_pos(pos_t pos, int delta, int screen, int csize);
    int bound;
    int v;
    bound = screen - csize;
    v = int'(pos) + delta;
    if (bound > 4095)
      bound = 4095;
    if (v >= bound)
      v = bound;
    if (v < 0)
      v = 0;
    return pos_t'(v);
  endfunction

  function automatic cursor_beat_t track_packet(packet_t p);
    cursor_beat_t b;
    int dx;
    int dy;
    dx = int'(p.xmove) - (p.status[STATUS_X_SIGN] ? 256 : 0);
    // Packet Y counts upward, screen rows count downward.
    dy = (p.status[STATUS_Y_SIGN] ? 256 : 0) - int'(p.ymove);
    case (p.status[2:0])
      STATUS_LEFT:   b.btn = BTN_LEFT;
      STATUS_RIGHT:  b.btn = BTN_RIGHT;
      STATUS_MIDDLE: b.btn = BTN_MIDDLE;
      default:       b.btn = BTN_NONE;
    endcase
    trk_x = clamp_pos(trk_x, dx, screen_w_cfg, int'(CURSOR_WIDTH));
    trk_y = clamp_pos(trk_y, dy, screen_h_cfg, int'(CURSOR_HEIGHT));
    b.x = trk_x;
    b.y = trk_y;
    b.click = 1'b0;
    b.click_btn = BTN_NONE;
    if (b.btn == BTN_NONE) begin
      if (held_btn != BTN_NONE) begin
        b.click = 1'b1;
        b.click_btn = held_btn;
      end
      held_btn = BTN_NONE;
    end else begin
      held_btn = b.btn;
    end
    return b;
  endfunction

  function automatic packet_t rand_packet();
    packet_t p;
    int pick;
    logic [8:0] mx;
    logic [8:0] my;
    p.status = 8'($urandom);
    p.xmove = 8'($urandom);
    p.ymove = 8'($urandom);
    mx = {p.status[STATUS_X_SIGN], p.xmove};
    my = {p.status[STATUS_Y_SIGN], p.ymove};
    // Mostly single presses and releases, so that clicks complete often.
    pick = $urandom_range(99);
    if (pick < 35) begin
      p.status[2:0] = 3'b000;
    end else if (pick < 85) begin
      case ($urandom_range(2))
        0:       p.status[2:0] = STATUS_LEFT;
        1:       p.status[2:0] = STATUS_RIGHT;
        default: p.status[2:0] = STATUS_MIDDLE;
      endcase
    end
    // Small moves keep the cursor inside; full-range moves reach the edges.
    pick = $urandom_range(99);
    if (pick < 55) begin
      mx = 9'($urandom_range(16)) - 9'd8;
      my = 9'($urandom_range(16)) - 9'd8;
    end else if (pick < 80) begin
      mx = 9'($urandom_range(128)) - 9'd64;
      my = 9'($urandom_range(128)) - 9'd64;
    end
    {p.status[STATUS_X_SIGN], p.xmove} = mx;
    {p.status[STATUS_Y_SIGN], p.ymove} = my;
    return p;
  endfunction

  task automatic send_packet(input packet_t p, input logic fixed, input cursor_beat_t typed_beat);
    cursor_beat_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      packet_bus.valid = 1'b0;
      @(negedge clk);
    end
    packet_bus.valid = 1'b1;
    packet_bus.status_byte = p.status;
    packet_bus.x_move_byte = p.xmove;
    packet_bus.y_move_byte = p.ymove;
    @(posedge clk);
    while (!packet_bus.ready)
      @(posedge clk);
    predicted = track_packet(p);
    pending_cursor_beats.push_back(fixed ? typed_beat : predicted);
    packets_sent++;
  endtask

  task automatic drain_cursor();
    @(negedge clk);
    packet_bus.valid = 1'b0;
    while (pending_cursor_beats.size() != 0)
      @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    if (reg_idx == REG_SCREEN_WIDTH)
      screen_w_cfg = int'(value[SCREEN_W-1:0]);
    else
      screen_h_cfg = int'(value[SCREEN_W-1:0]);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    cursor_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        cursor_bus.ready = 1'b0;
        stall_left--;
      end else begin
        cursor_bus.ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cursor_beat_t want;
    cursor_beat_t got;
    if (!rst && cursor_bus.valid && cursor_bus.ready) begin
      got.x = cursor_bus.cursor_x;
      got.y = cursor_bus.cursor_y;
      got.btn = cursor_bus.button_code;
      got.click = cursor_bus.click_valid;
      got.click_btn = cursor_bus.click_button;
      if (got.click)
        clicks_seen++;
      if (pending_cursor_beats.size() == 0) begin
        cursor_mismatches++;
        if (cursor_mismatches <= REPORT_LIMIT)
          $display("%0t: cursor beat with nothing expected: x=%0d y=%0d btn=%0d click=%0b/%0d",
                   $realtime, got.x, got.y, got.btn, got.click, got.click_btn);
      end else begin
        want = pending_cursor_beats.pop_front();
        beats_checked++;
        if (got.x !== want.x || got.y !== want.y || got.btn !== want.btn ||
            got.click !== want.click || got.click_btn !== want.click_btn) begin
          cursor_mismatches++;
          if (cursor_mismatches <= REPORT_LIMIT)
            $display("%0t: beat %0d expected x=%0d y=%0d btn=%0d click=%0b/%0d, got x=%0d y=%0d btn=%0d click=%0b/%0d",
                     $realtime, beats_checked, want.x, want.y, want.btn, want.click,
                     want.click_btn, got.x, got.y, got.btn, got.click, got.click_btn);
        end
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] width_word;
    logic [DATA_W-1:0] height_word;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    packet_bus.valid = 1'b0;
    packet_bus.status_byte = '0;
    packet_bus.x_move_byte = '0;
    packet_bus.y_move_byte = '0;
    stall_request = 0;
    cycle_count = 0;
    packets_sent = 0;
    beats_checked = 0;
    clicks_seen = 0;
    cursor_mismatches = 0;
    settings_used = 1;
    src_idle_pct = 20;
    snk_idle_pct = 76;
    trk_x = POS_X_RESET;
    trk_y = POS_Y_RESET;
    held_btn = BTN_NONE;
    screen_w_cfg = int'(SCREEN_WIDTH_RESET);
    screen_h_cfg = int'(SCREEN_HEIGHT_RESET);

    // Default 1024x768 screen: X tops out at 1014, Y at 751.
    directed_rows.push_back({8'h08, 8'h00, 8'h00, 1'b1, 12'd512, 12'd384, BTN_NONE, 1'b0, BTN_NONE});
    directed_rows.push_back({8'h09, 8'hFF, 8'h00, 1'b1, 12'd767, 12'd384, BTN_LEFT, 1'b0, BTN_NONE});
    directed_rows.push_back({8'h08, 8'h00, 8'h00, 1'b1, 12'd767, 12'd384, BTN_NONE, 1'b1, BTN_LEFT});
    directed_rows.push_back({8'h19, 8'h00, 8'h00, 1'b1, 12'd511, 12'd384, BTN_LEFT, 1'b0, BTN_NONE});
    directed_rows.push_back({8'h0A, 8'h00, 8'hFF, 1'b1, 12'd511, 12'd129, BTN_RIGHT, 1'b0, BTN_NONE});
    directed_rows.push_back({8'h0C, 8'h00, 8'h00, 1'b1, 12'd511, 12'd129, BTN_MIDDLE, 1'b0, BTN_NONE});
    directed_rows.push_back({8'h0F, 8'h00, 8'h00, 1'b1, 12'd511, 12'd129, BTN_NONE, 1'b1, BTN_MIDDLE});
    directed_rows.push_back({8'h0F, 8'h00, 8'h00, 1'b1, 12'd511, 12'd129, BTN_NONE, 1'b0, BTN_NONE});
    directed_rows.push_back({8'h28, 8'h00, 8'h00, 1'b1, 12'd511, 12'd385, BTN_NONE, 1'b0, BTN_NONE});
    directed_rows.push_back({8'h28, 8'h00, 8'h01, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h28, 8'h00, 8'h01, 1'b1, 12'd511, 12'd751, BTN_NONE, 1'b0, BTN_NONE});
    directed_rows.push_back({8'h08, 8'hFF, 8'h00, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h09, 8'hFF, 8'h00, 1'b1, 12'd1014, 12'd751, BTN_LEFT, 1'b0, BTN_NONE});
    directed_rows.push_back({8'h10, 8'h00, 8'h00, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h18, 8'h00, 8'h00, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h18, 8'h01, 8'h00, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h18, 8'hFF, 8'h00, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h18, 8'h00, 8'h00, 1'b1, 12'd0, 12'd751, BTN_NONE, 1'b0, BTN_NONE});
    directed_rows.push_back({8'h08, 8'h00, 8'hFF, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h08, 8'h00, 8'hFF, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h08, 8'h00, 8'hFF, 1'b1, 12'd0, 12'd0, BTN_NONE, 1'b0, BTN_NONE});
    directed_rows.push_back({8'hC8, 8'h80, 8'h80, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h03, 8'h00, 8'h00, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h05, 8'h00, 8'h00, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h06, 8'h00, 8'h00, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h01, 8'h7F, 8'h00, 1'b0, NO_BEAT});
    directed_rows.push_back({8'h00, 8'h00, 8'h7F, 1'b0, NO_BEAT});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_packet(directed_rows[i].pkt, directed_rows[i].fixed, directed_rows[i].beat);
    drain_cursor();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          width_word = 32'd4096;
          height_word = 32'd4096;
        end
        1: begin
          // Screen no larger than the cursor pins it to the corner.
          width_word = 32'd10;
          height_word = 32'd17;
        end
        3: begin
          // Bits above the register width must be dropped.
          width_word = {19'h5A5A5, 13'd800};
          height_word = {19'h2D2D2, 13'd600};
        end
        5: begin
          width_word = 32'(SCREEN_WIDTH_RESET);
          height_word = 32'(SCREEN_HEIGHT_RESET);
        end
        default: begin
          width_word = 32'($urandom_range(4096, 10));
          height_word = 32'($urandom_range(4096, 17));
        end
      endcase
      apb_write(REG_SCREEN_WIDTH, width_word);
      apb_write(REG_SCREEN_HEIGHT, height_word);
      settings_used++;

      if (phase < 2) begin
        src_idle_pct = 20;
        snk_idle_pct = 76;
      end else if (phase < 4) begin
        src_idle_pct = 76;
        snk_idle_pct = 20;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (phase == 4)
        stall_request = 400;

      repeat (PHASE_ITEMS)
        send_packet(rand_packet(), 1'b0, NO_BEAT);
      drain_cursor();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d packets under %0d screen settings; checked %0d cursor beats, %0d clicks.",
             packets_sent, settings_used, beats_checked, clicks_seen);
    $display("Mismatches: %0d", cursor_mismatches);
    if (cursor_mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mpct_pkg.sv
rtl/mpct_if.sv
rtl/mpct_axis_clamp.sv
rtl/mouse_packet_cursor_tracker_unit.sv
sim/testbench.sv
